[design/ppp_pkg.sv]
package ppp_pkg;

    localparam int COORD_BITS = 12;
    localparam int TRIG_W     = 16;
    localparam int DIST_W     = 16;
    localparam int FOCAL_W    = 10;
    localparam int SCREEN_W   = 16;
    localparam int QBITS      = SCREEN_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AZIM_SIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AZIM_COS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_PHI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COS_PHI   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd5;

    localparam logic [QBITS-1:0] POS_LIMIT = QBITS'(17'd32767);
    localparam logic [QBITS-1:0] NEG_LIMIT = QBITS'(17'd32768);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] world_x;
        logic signed [COORD_BITS-1:0] world_y;
        logic signed [COORD_BITS-1:0] world_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic                       behind_camera;
        logic                       clipped;
    } out_beat_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] azim_sin;
        logic signed [TRIG_W-1:0] azim_cos;
        logic signed [TRIG_W-1:0] sin_phi;
        logic signed [TRIG_W-1:0] cos_phi;
        logic [DIST_W-1:0]        camera_distance;
        logic [FOCAL_W-1:0]       focal_distance;
    } cfg_t;

    typedef struct packed {
        logic [QBITS-1:0] quot;
        logic             ovf;
        logic             neg;
    } lane_res_t;

    typedef struct packed {
        logic signed [SCREEN_W-1:0] value;
        logic                       sat;
    } sat_res_t;

    // width of a view coordinate for a given trig fraction width
    function automatic int view_width(input int fb);
        int m1;
        int m2;
        int m3;
        int mx;
        m1 = COORD_BITS + 2 * TRIG_W - 3;
        m2 = COORD_BITS + TRIG_W - 2 + fb;
        m3 = 2 * fb + DIST_W - 4;
        mx = (m1 > m2) ? m1 : m2;
        mx = (mx > m3) ? mx : m3;
        return mx + 3;
    endfunction

    function automatic sat_res_t saturate(input lane_res_t r);
        sat_res_t s;
        s.sat = 1'b0;
        if (r.neg) begin
            if (r.ovf || (r.quot > NEG_LIMIT)) begin
                s.sat   = 1'b1;
                s.value = $signed(NEG_LIMIT[SCREEN_W-1:0]);
            end
            else begin
                s.value = $signed(SCREEN_W'(-r.quot));
            end
        end
        else begin
            if (r.ovf || (r.quot > POS_LIMIT)) begin
                s.sat   = 1'b1;
                s.value = $signed(POS_LIMIT[SCREEN_W-1:0]);
            end
            else begin
                s.value = $signed(r.quot[SCREEN_W-1:0]);
            end
        end
        return s;
    endfunction

endpackage

[design/ppp_rotate.sv]
module ppp_rotate #(
    parameter int FB = 14,
    parameter int VW = 46
) (
    input  logic                 clk,
    input  logic                 en,
    input  ppp_pkg::in_beat_t    in_beat,
    input  ppp_pkg::cfg_t        cfg,
    output logic signed [VW-1:0] vx,
    output logic signed [VW-1:0] vy,
    output logic signed [VW-1:0] vz
);
    import ppp_pkg::*;

    localparam int PW = COORD_BITS + TRIG_W;
    localparam int TW = COORD_BITS + 2 * TRIG_W;
    localparam int RHO_SH = 2 * FB - 4;

    // stage 1: single trig products
    logic signed [PW-1:0] xst_reg, yct_reg, xct_reg, yst_reg, zsp_reg, zcp_reg;
    // stage 2: double trig products, the x difference and the delayed z products
    logic signed [TW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [PW:0]   vxp_reg;
    logic signed [PW-1:0] zsp2_reg, zcp2_reg;
    // stage 3: sums
    logic signed [VW-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [VW-1:0] rho_term;

    assign rho_term = VW'($signed({1'b0, cfg.camera_distance})) <<< RHO_SH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xst_reg  <= PW'(in_beat.world_x) * PW'(cfg.azim_sin);
            yct_reg  <= PW'(in_beat.world_y) * PW'(cfg.azim_cos);
            xct_reg  <= PW'(in_beat.world_x) * PW'(cfg.azim_cos);
            yst_reg  <= PW'(in_beat.world_y) * PW'(cfg.azim_sin);
            zsp_reg  <= PW'(in_beat.world_z) * PW'(cfg.sin_phi);
            zcp_reg  <= PW'(in_beat.world_z) * PW'(cfg.cos_phi);

            a_reg    <= TW'(xct_reg) * TW'(cfg.cos_phi);
            b_reg    <= TW'(yst_reg) * TW'(cfg.cos_phi);
            c_reg    <= TW'(xct_reg) * TW'(cfg.sin_phi);
            d_reg    <= TW'(yst_reg) * TW'(cfg.sin_phi);
            vxp_reg  <= (PW+1)'(yct_reg) - (PW+1)'(xst_reg);
            zsp2_reg <= zsp_reg;
            zcp2_reg <= zcp_reg;

            vx_reg   <= VW'(vxp_reg) <<< FB;
            vy_reg   <= (VW'(zsp2_reg) <<< FB) - VW'(a_reg) - VW'(b_reg);
            vz_reg   <= rho_term - (VW'(zcp2_reg) <<< FB) - VW'(c_reg) - VW'(d_reg);
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;
    assign vz = vz_reg;

endmodule

[design/ppp_div_lane.sv]
module ppp_div_lane #(
    parameter int VW = 46
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [VW-1:0]            v,
    input  logic [VW-2:0]                   den,
    input  logic [ppp_pkg::FOCAL_W-1:0]     focal,
    output ppp_pkg::lane_res_t              res
);
    import ppp_pkg::*;

    localparam int NW = VW + FOCAL_W;
    localparam int RW = VW + QBITS;

    logic [VW-1:0]   mag_a_reg;
    logic [VW-2:0]   den_a_reg;
    logic            neg_a_reg;
    logic [NW-1:0]   num_b_reg;
    logic [VW-2:0]   den_b_reg;
    logic            neg_b_reg;

    logic [RW-1:0]    rem_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic [VW-2:0]    den_reg [0:QBITS];
    logic             neg_reg [0:QBITS];
    logic             ovf_reg [0:QBITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg  <= v[VW-1] ? VW'(-v) : VW'(v);
            den_a_reg  <= den;
            neg_a_reg  <= v[VW-1];
            num_b_reg  <= NW'(mag_a_reg) * NW'(focal);
            den_b_reg  <= den_a_reg;
            neg_b_reg  <= neg_a_reg;
            rem_reg[0] <= RW'(num_b_reg);
            q_reg[0]   <= '0;
            den_reg[0] <= den_b_reg;
            neg_reg[0] <= neg_b_reg;
            ovf_reg[0] <= RW'(num_b_reg) >= (RW'(den_b_reg) << QBITS);
        end
    end

    for (genvar i = 0; i < QBITS; i++)
    begin : g_step
        localparam int K = QBITS - 1 - i;
        logic [RW-1:0] dsh;
        logic          fit;
        assign dsh = RW'(den_reg[i]) << K;
        assign fit = rem_reg[i] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= fit ? (rem_reg[i] - dsh) : rem_reg[i];
                q_reg[i+1]   <= q_reg[i] | (QBITS'(fit) << K);
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    assign res.quot = q_reg[QBITS];
    assign res.ovf  = ovf_reg[QBITS];
    assign res.neg  = neg_reg[QBITS];

endmodule

[design/perspective_point_projection_core.sv]
// Perspective projection of world-space vertices: each beat is rotated into
// camera view space from the configured trig terms and camera distance, then
// divided by view depth and scaled by the focal distance, truncated toward zero
// and saturated to 16 bits. One vertex is accepted per clock unless the
// pipeline is held; it has 3 rotation stages, abs and focal multiply, an
// overflow check and 17 one-bit restoring divide stages per coordinate and an
// output register. The whole pipeline holds while a result waits on out_stall.
// The user must write configuration only while idle; the block does not enforce it.
module perspective_point_projection_core #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ppp_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ppp_pkg::out_beat_t                out_data,
    input  logic                              cfg_wr_en,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ppp_pkg::*;

    localparam int VW       = view_width(TRIG_FRAC_BITS);
    localparam int ROT_LAT  = 3;
    localparam int LANE_LAT = 3 + QBITS;
    localparam int PIPE     = ROT_LAT + LANE_LAT;

    cfg_t cfg_reg;
    logic adv;
    logic [PIPE-1:0]     valid_reg;
    logic [LANE_LAT-1:0] behind_reg;
    out_beat_t           out_reg;
    logic                out_valid_reg;

    logic signed [VW-1:0] vx, vy, vz;
    logic                 behind;
    lane_res_t            res_x, res_y;
    sat_res_t             sat_x, sat_y;
    out_beat_t            out_next;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.azim_sin        <= 16'sd11585;
            cfg_reg.azim_cos        <= 16'sd11585;
            cfg_reg.sin_phi         <= 16'sd13377;
            cfg_reg.cos_phi         <= 16'sd9459;
            cfg_reg.camera_distance <= 16'd2771;
            cfg_reg.focal_distance  <= 10'd100;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_AZIM_SIN:  cfg_reg.azim_sin        <= $signed(cfg_wr_data);
                REG_AZIM_COS:  cfg_reg.azim_cos        <= $signed(cfg_wr_data);
                REG_SIN_PHI:   cfg_reg.sin_phi         <= $signed(cfg_wr_data);
                REG_COS_PHI:   cfg_reg.cos_phi         <= $signed(cfg_wr_data);
                REG_CAM_DIST:  cfg_reg.camera_distance <= cfg_wr_data;
                REG_FOCAL:     cfg_reg.focal_distance  <= cfg_wr_data[FOCAL_W-1:0];
                default:       ;
            endcase
        end
    end

    ppp_rotate #(.FB(TRIG_FRAC_BITS), .VW(VW)) u_rotate (
        .clk     (clk),
        .en      (adv),
        .in_beat (in_data),
        .cfg     (cfg_reg),
        .vx      (vx),
        .vy      (vy),
        .vz      (vz)
    );

    assign behind = vz[VW-1] || (vz == '0);

    ppp_div_lane #(.VW(VW)) u_lane_x (
        .clk   (clk),
        .en    (adv),
        .v     (vx),
        .den   (vz[VW-2:0]),
        .focal (cfg_reg.focal_distance),
        .res   (res_x)
    );

    ppp_div_lane #(.VW(VW)) u_lane_y (
        .clk   (clk),
        .en    (adv),
        .v     (vy),
        .den   (vz[VW-2:0]),
        .focal (cfg_reg.focal_distance),
        .res   (res_y)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            behind_reg <= {behind_reg[LANE_LAT-2:0], behind};
            out_reg    <= out_next;
        end
    end

    always_comb
    begin
        sat_x = saturate(res_x);
        sat_y = saturate(res_y);
        if (behind_reg[LANE_LAT-1])
        begin
            out_next.screen_x      = '0;
            out_next.screen_y      = '0;
            out_next.behind_camera = 1'b1;
            out_next.clipped       = 1'b0;
        end
        else
        begin
            out_next.screen_x      = sat_x.value;
            out_next.screen_y      = sat_y.value;
            out_next.behind_camera = 1'b0;
            out_next.clipped       = sat_x.sat || sat_y.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[PIPE-2:0], in_valid};
            out_valid_reg <= valid_reg[PIPE-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.behind_camera) |->
        (out_data.screen_x == '0 && out_data.screen_y == '0 && !out_data.clipped))
        else $error("behind-camera beat carries coordinates");

    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.clipped) |->
        (out_data.screen_x == 16'sh7fff || out_data.screen_x == 16'sh8000 ||
         out_data.screen_y == 16'sh7fff || out_data.screen_y == 16'sh8000))
        else $error("clipped beat not at a saturation limit");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
